@@ hdl/lsr_pkg.sv @@
// Shared constants for the literal substring replacer.
`timescale 1ns / 1ps
package lsr_pkg;

  // Default and upper bound of the pattern size in bytes
  localparam int MAX_PATTERN_BYTES_DEF = 8;

  // Configuration port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

endpackage

@@ hdl/lsr_front.sv @@
// Front end: config registers, pending window, needle compare, command build.
`timescale 1ns / 1ps
module lsr_front #(
  parameter int P = lsr_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_byte,
  input  logic                             in_end_of_input,
  input  logic                             in_no_data,
  output logic                             cmd_push,
  output logic [1+$clog2(P+1)+8*P-1:0]     cmd_data,
  input  logic                             q_full
);
  import lsr_pkg::*;

  localparam int CW = $clog2(P + 1);

  logic [CFG_DATA_W-1:0] needle_r;
  logic [LEN_W-1:0]      nlen_r;
  logic [CFG_DATA_W-1:0] repl_r;
  logic [LEN_W-1:0]      rlen_r;
  logic [7:0]            win_r   [P];
  logic [7:0]            win_nxt [P];
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  logic [7:0]    win_app [P];
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] nlen_eff;
  logic [CW-1:0] rlen_eff;
  logic          hit;
  logic          win_full;
  logic          accept;
  logic [8*P-1:0] emit_bytes;
  logic [CW-1:0]  emit_cnt;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Saturate lengths to the window size
  assign nlen_eff = (nlen_r > LEN_W'(P)) ? CW'(P) : nlen_r[CW-1:0];
  assign rlen_eff = (rlen_r > LEN_W'(P)) ? CW'(P) : rlen_r[CW-1:0];

  // Append the new byte, compare, and decide what to emit
  always_comb begin
    for (int i = 0; i < P; i++) begin
      win_app[i] = (!in_no_data && count_r == CW'(i)) ? in_byte : win_r[i];
    end
    cnt_a = count_r + CW'(!in_no_data);

    hit = 1'b1;
    for (int i = 0; i < P; i++) begin
      if (CW'(i) < nlen_eff && win_app[i] != needle_r[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    win_full = (nlen_eff != '0) && !in_no_data && (cnt_a == nlen_eff);

    for (int i = 0; i < P; i++) begin
      emit_bytes[8*i +: 8] = win_app[i];
      win_nxt[i]           = win_app[i];
    end

    if (nlen_eff == '0) begin
      // pass through
      emit_cnt  = cnt_a;
      count_nxt = '0;
    end else if (win_full && hit) begin
      emit_bytes = repl_r[8*P-1:0];
      emit_cnt   = rlen_eff;
      count_nxt  = '0;
    end else if (win_full) begin
      // miss: oldest byte out, or whole window at end of string
      emit_cnt  = in_end_of_input ? cnt_a : CW'(1);
      count_nxt = in_end_of_input ? '0 : cnt_a - CW'(1);
      for (int i = 0; i < P - 1; i++) begin
        win_nxt[i] = win_app[i + 1];
      end
    end else begin
      emit_cnt  = in_end_of_input ? cnt_a : '0;
      count_nxt = in_end_of_input ? '0 : cnt_a;
    end
  end

  assign cmd_push = accept && (emit_cnt != '0 || in_end_of_input);
  assign cmd_data = {in_end_of_input, emit_cnt, emit_bytes};

  // Config registers and pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
      nlen_r   <= '0;
      repl_r   <= '0;
      rlen_r   <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEEDLE_BYTES:       needle_r <= cfg_data;
        CFG_NEEDLE_LENGTH:      nlen_r   <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  repl_r   <= cfg_data;
        CFG_REPLACEMENT_LENGTH: rlen_r   <= cfg_data[LEN_W-1:0];
        default:                ;
      endcase
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Window contents, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Window never holds a full needle between items
  a_count_below_needle: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 || count_r < nlen_eff)
    else $error("pending count reached needle length");

  // A string end always produces a command
  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_input) |-> cmd_push)
    else $error("end of string without command");
`endif

endmodule

@@ hdl/lsr_cmd_fifo.sv @@
// Short command queue between front and back ends.
`timescale 1ns / 1ps
module lsr_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_valid
);
  import lsr_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  // Fill count rises by one on a push without a pop
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd && !q_full) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("command queue count lost a push");
`endif

endmodule

@@ hdl/lsr_back.sv @@
// Back end: walks each command and emits one result per cycle while results are popped.
`timescale 1ns / 1ps
module lsr_back #(
  parameter int P = lsr_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  logic [1+$clog2(P+1)+8*P-1:0] cmd_data,
  output logic                         cmd_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         out_end_of_output,
  output logic                         out_empty_marker
);
  import lsr_pkg::*;

  localparam int CW = $clog2(P + 1);
  localparam int IW = (P > 1) ? $clog2(P) : 1;

  logic [8*P-1:0] cmd_bytes;
  logic [CW-1:0]  cmd_cnt;
  logic           cmd_last;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_end_r;
  logic          out_empty_r;
  logic [IW-1:0] idx_r, idx_nxt;

  logic pop_acc, load, last_beat;

  assign {cmd_last, cmd_cnt, cmd_bytes} = cmd_data;

  assign pop_acc   = pop && out_valid_r;
  assign load      = cmd_valid && (!out_valid_r || pop_acc);
  assign last_beat = (cmd_cnt == '0) || (CW'(idx_r) == cmd_cnt - CW'(1));
  assign cmd_pop   = load && last_beat;
  assign idx_nxt   = last_beat ? '0 : idx_r + IW'(1);

  // Output register and command beat index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= idx_nxt;
    end else if (pop_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_empty_r <= (cmd_cnt == '0);
      out_end_r   <= cmd_last && last_beat;
      out_byte_r  <= (cmd_cnt == '0) ? 8'd0 : cmd_bytes[8*idx_r +: 8];
    end
  end

  assign empty             = !out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_end_of_output = out_end_r;
  assign out_empty_marker  = out_empty_r;

`ifndef ASSERT_OFF
  // A terminator-only result always closes the string
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_end_r)
    else $error("empty marker without end of output");

  // Beat index restarts once a command is retired
  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (idx_r == '0))
    else $error("beat index not cleared after command");
`endif

endmodule

@@ hdl/literal_substring_replacer_unit.sv @@
// Top level of the literal substring replacer.
`timescale 1ns / 1ps
// Streams a string one byte per request and replaces each leftmost,
// non-overlapping occurrence of the configured needle with the configured
// replacement; a needle length of zero passes bytes through. The front end
// accepts one input request per cycle while full is low, compares the
// pending window with the needle in parallel and queues a command for each
// request that yields results or ends a string in a two-entry queue; the
// back end emits one result per cycle from a single output register while
// results are popped. An item that yields k results occupies the back end
// until all k are emitted, so the sustained rate is one byte per cycle and
// full rises only while a replacement or an end-of-string flush emits
// several bytes, or while results are not popped. Results pass the command
// queue register, then the output register. Configuration writes discard
// the pending window and must be made while the block is idle.
module literal_substring_replacer_unit #(
  parameter int MAX_PATTERN_BYTES = lsr_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_end_of_input,
  input  logic                           in_no_data,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_end_of_output,
  output logic                           out_empty_marker
);
  import lsr_pkg::*;

  localparam int CMD_W = 1 + $clog2(MAX_PATTERN_BYTES + 1) + 8 * MAX_PATTERN_BYTES;

  logic             cmd_push, q_full, q_valid, cmd_pop;
  logic [CMD_W-1:0] cmd_wr_data, cmd_rd_data;

  // Front end
  lsr_front #(.P(MAX_PATTERN_BYTES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .in_no_data      (in_no_data),
    .cmd_push        (cmd_push),
    .cmd_data        (cmd_wr_data),
    .q_full          (q_full)
  );

  // Command queue
  lsr_cmd_fifo #(.WIDTH(CMD_W)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr_data),
    .q_full  (q_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_data),
    .q_valid (q_valid)
  );

  // Back end
  lsr_back #(.P(MAX_PATTERN_BYTES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_data          (cmd_rd_data),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_end_of_output (out_end_of_output),
    .out_empty_marker  (out_empty_marker)
  );

endmodule

@@ verif/tb_literal_substring_replacer_unit.sv @@
// Self-checking testbench for the literal substring replacer unit.
`timescale 1ns / 1ps
module tb_literal_substring_replacer_unit;
  import lsr_pkg::*;

  localparam int MAXP         = MAX_PATTERN_BYTES_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       marker;
  } replaced_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic [7:0]            in_byte;
  logic                  in_end_of_input;
  logic                  in_no_data;
  logic                  empty;
  logic                  pop;
  logic [7:0]            out_byte;
  logic                  out_end_of_output;
  logic                  out_empty_marker;

  literal_substring_replacer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_end_of_input   (in_end_of_input),
    .in_no_data        (in_no_data),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_end_of_output (out_end_of_output),
    .out_empty_marker  (out_empty_marker)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state: registers and pending window
  logic [63:0]    pred_needle;
  logic [3:0]     pred_needle_len;
  logic [63:0]    pred_repl;
  logic [3:0]     pred_repl_len;
  logic [7:0]     pend_win [0:7];
  int             pend_cnt;
  replaced_byte_t expected_q [$];
  replaced_byte_t got_exp;

  // Stimulus control and statistics
  bit             tx_idle;
  bit             rx_idle;
  int             rx_hold_cycles;
  logic [63:0]    cur_needle;
  int             cur_nlen;
  logic [7:0]     str_q [$];
  int             fail_cnt;
  int             req_cnt;
  int             res_cnt;
  int             hit_cnt;
  int             cfg_cnt;
  int             stall_cnt;
  int             phase_cnt;
  int             idle_cnt;

  function automatic int sat_len(logic [3:0] v);
    return (v > MAXP) ? MAXP : int'(v);
  endfunction

  function automatic void drop_pending(int k);
    int i;
    for (i = 0; i < 8; i++)
      if (i + k < 8) pend_win[i] = pend_win[i + k];
    pend_cnt = (k >= pend_cnt) ? 0 : pend_cnt - k;
  endfunction

  // Work out the results one accepted request causes
  function automatic void predict_replace(logic [7:0] b, logic eoi, logic nd);
    replaced_byte_t res [0:7];
    int             nl;
    int             rl;
    int             n;
    int             i;
    bit             hit;
    nl = sat_len(pred_needle_len);
    rl = sat_len(pred_repl_len);
    n  = 0;
    if (!nd) begin
      if (nl == 0) begin
        res[n] = '{data: b, last: 1'b0, marker: 1'b0};
        n++;
      end else begin
        if (pend_cnt < MAXP) begin
          pend_win[pend_cnt] = b;
          pend_cnt++;
        end
        if (pend_cnt >= nl) begin
          hit = 1'b1;
          for (i = 0; i < nl; i++)
            if (pend_win[i] != pred_needle[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            hit_cnt++;
            for (i = 0; i < rl; i++) begin
              res[n] = '{data: pred_repl[8*i +: 8], last: 1'b0, marker: 1'b0};
              n++;
            end
            drop_pending(nl);
          end else begin
            res[n] = '{data: pend_win[0], last: 1'b0, marker: 1'b0};
            n++;
            drop_pending(1);
          end
        end
      end
    end
    if (eoi) begin
      for (i = 0; i < pend_cnt && n < 8; i++) begin
        res[n] = '{data: pend_win[i], last: 1'b0, marker: 1'b0};
        n++;
      end
      pend_cnt = 0;
      if (n == 0) begin
        res[0] = '{data: 8'h00, last: 1'b0, marker: 1'b1};
        n = 1;
      end
      res[n-1].last = 1'b1;
    end
    for (i = 0; i < n; i++) expected_q.push_back(res[i]);
  endfunction

  // Monitor: track register writes, predict accepted requests, check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        cfg_cnt++;
        case (cfg_index)
          CFG_NEEDLE_BYTES:       pred_needle     = cfg_data;
          CFG_NEEDLE_LENGTH:      pred_needle_len = cfg_data[LEN_W-1:0];
          CFG_REPLACEMENT_BYTES:  pred_repl       = cfg_data;
          CFG_REPLACEMENT_LENGTH: pred_repl_len   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
        pend_cnt = 0;
      end
      if (push && full) stall_cnt++;
      if (push && !full) begin
        if (!(in_no_data && !in_end_of_input)) req_cnt++;
        predict_replace(in_byte, in_end_of_input, in_no_data);
      end
      if (pop && !empty) begin
        res_cnt++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: out_byte=%02h end=%0b marker=%0b",
                 out_byte, out_end_of_output, out_empty_marker);
          fail_cnt++;
        end else begin
          got_exp = expected_q.pop_front();
          if (out_byte !== got_exp.data) begin
            $error("out_byte: expected %02h, got %02h", got_exp.data, out_byte);
            fail_cnt++;
          end
          if (out_end_of_output !== got_exp.last) begin
            $error("out_end_of_output: expected %0b, got %0b",
                   got_exp.last, out_end_of_output);
            fail_cnt++;
          end
          if (out_empty_marker !== got_exp.marker) begin
            $error("out_empty_marker: expected %0b, got %0b",
                   got_exp.marker, out_empty_marker);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or write
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || !rst_n)
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver with random gaps and an optional long hold-off
  initial begin
    int gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Offer one request; push stays high afterwards for a back-to-back request
  task automatic send_req(input logic [7:0] b, input logic eoi, input logic nd);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push            <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    in_no_data      <= nd;
    do @(posedge clk); while (full);
  endtask

  // Stop offering, wait for every expected result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_all(input logic [63:0] nb, input logic [63:0] nl,
                             input logic [63:0] rb, input logic [63:0] rl);
    write_reg(CFG_NEEDLE_BYTES, nb);
    write_reg(CFG_NEEDLE_LENGTH, nl);
    write_reg(CFG_REPLACEMENT_BYTES, rb);
    write_reg(CFG_REPLACEMENT_LENGTH, rl);
    cur_needle = nb;
    cur_nlen   = sat_len(nl[3:0]);
  endtask

  // Send str_q as one string, ended on its last byte or by a terminator
  task automatic send_string(input bit sep_term);
    int i;
    if (str_q.size() == 0) begin
      send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      for (i = 0; i < str_q.size(); i++) begin
        if ($urandom_range(0, 14) == 0) send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_req(str_q[i], (i == str_q.size() - 1) && !sep_term, 1'b0);
      end
      if (sep_term) send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endtask

  // Random string rich in needles and needle fragments
  task automatic build_string();
    int len;
    int r;
    int k;
    int pos;
    str_q.delete();
    len = $urandom_range(1, 12);
    while (str_q.size() < len) begin
      r = $urandom_range(0, 9);
      if (cur_nlen > 0 && r < 3) begin
        for (k = 0; k < cur_nlen; k++) str_q.push_back(cur_needle[8*k +: 8]);
      end else if (cur_nlen > 0 && r < 6) begin
        pos = $urandom_range(0, cur_nlen - 1);
        str_q.push_back(cur_needle[8*pos +: 8]);
      end else begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic logic [63:0] pick_len();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0:       v[3:0] = 4'd0;
      1:       v[3:0] = 4'd1;
      2:       v[3:0] = 4'($urandom_range(2, 4));
      3:       v[3:0] = 4'd8;
      4:       v[3:0] = 4'($urandom_range(9, 15));
      default: v[3:0] = 4'($urandom_range(0, 15));
    endcase
    if ($urandom_range(0, 1)) v[63:4] = '0;
    return v;
  endfunction

  // Reset configuration passes bytes through; terminator and ignored requests
  task automatic test_passthrough();
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h5A, 1'b0, 1'b1);
    send_req(8'hC3, 1'b1, 1'b1);
    send_req(8'hA5, 1'b1, 1'b0);
    settle();
  endtask

  // Two-byte needle grown into a three-byte replacement
  task automatic test_basic_replace();
    program_all(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    str_q = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h62};
    send_string(1'b0);
    settle();
  endtask

  // Widest needle and replacement, lengths above the maximum saturate,
  // plus deletion with an empty replacement
  task automatic test_extremes();
    program_all({8{8'hFF}}, 64'd15, 64'h0, 64'd9);
    str_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_string(1'b0);
    settle();
    program_all(64'h0, 64'd1, {8{8'hFF}}, 64'd0);
    str_q = '{8'h00};
    send_string(1'b0);
    str_q = '{8'h01, 8'h00};
    send_string(1'b0);
    settle();
  endtask

  // A register write in the middle of a string drops the pending window
  task automatic test_midstring_write();
    program_all(64'h636261, 64'd3, 64'h2151, 64'd2);
    send_req(8'h78, 1'b0, 1'b0);
    send_req(8'h61, 1'b0, 1'b0);
    send_req(8'h62, 1'b0, 1'b0);
    settle();
    write_reg(CFG_REPLACEMENT_LENGTH, 64'd2);
    send_req(8'h63, 1'b1, 1'b0);
    settle();
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    program_all({$urandom(), $urandom()}, 64'd2, {$urandom(), $urandom()}, 64'd8);
    tx_idle = 1'b0;
    rx_hold_cycles = 150;
    for (i = 0; i < 30; i++)
      send_req((i % 3 == 2) ? 8'($urandom_range(0, 255)) : cur_needle[8*(i % 3) +: 8],
               i == 29, 1'b0);
    settle();
    tx_idle = 1'b1;
  endtask

  // Random phases, each under a fresh configuration
  task automatic test_random();
    int          start_cnt;
    int          phase_start;
    logic [63:0] nb;
    logic [63:0] nl;
    logic [63:0] rl;
    int          k;
    start_cnt = req_cnt;
    while (req_cnt - start_cnt < RANDOM_ITEMS) begin
      nb = {$urandom(), $urandom()};
      if ($urandom_range(0, 1))
        for (k = 0; k < 8; k++) nb[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      nl = pick_len();
      rl = pick_len();
      if (phase_cnt == 0) begin
        nl = 64'd8;
        rl = 64'd8;
      end else if (phase_cnt == 1) begin
        nl = 64'hFFFF_FFFF_FFFF_FFFF;
        rl = 64'd0;
      end
      program_all(nb, nl, {$urandom(), $urandom()}, rl);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      phase_start = req_cnt;
      while (req_cnt - phase_start < 40) begin
        if ($urandom_range(0, 9) == 0) str_q.delete();
        else build_string();
        send_string($urandom_range(0, 3) == 0);
      end
      settle();
      phase_cnt++;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_NEEDLE_BYTES;
    cfg_data        = '0;
    push            = 1'b0;
    in_byte         = 8'h00;
    in_end_of_input = 1'b0;
    in_no_data      = 1'b0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    rx_hold_cycles  = 0;
    pred_needle     = '0;
    pred_needle_len = '0;
    pred_repl       = '0;
    pred_repl_len   = '0;
    pend_cnt        = 0;
    cur_needle      = '0;
    cur_nlen        = 0;
    fail_cnt        = 0;
    req_cnt         = 0;
    res_cnt         = 0;
    hit_cnt         = 0;
    cfg_cnt         = 0;
    stall_cnt       = 0;
    phase_cnt       = 0;
    idle_cnt        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_basic_replace();
    test_extremes();
    test_midstring_write();
    test_backpressure();
    test_random();

    settle();
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      fail_cnt++;
    end
    $display("Covered %0d requests and %0d results, %0d needle hits, %0d register writes",
             req_cnt, res_cnt, hit_cnt, cfg_cnt);
    $display("over %0d random settings; input stalled on %0d cycles",
             phase_cnt, stall_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lsr_pkg.sv
hdl/lsr_front.sv
hdl/lsr_cmd_fifo.sv
hdl/lsr_back.sv
hdl/literal_substring_replacer_unit.sv
verif/tb_literal_substring_replacer_unit.sv
